FILE: rtl/core/lru_pr_pkg.sv
// Shared widths, word types and reset constants for the LRU page replacement block.
`timescale 1ns / 1ps

package lru_pr_pkg;

	localparam int PAGE_W = 16;
	localparam int TS_W   = 32;
	localparam int FC_W   = 5;
	localparam int FIDX_W = 4;

	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [TS_W-1:0]   ts_t;
	typedef logic [FC_W-1:0]   fc_t;
	typedef logic [FIDX_W-1:0] fidx_t;

	localparam fc_t FRAME_COUNT_RST = 5'd16;
	localparam ts_t TS_MAX          = '1;

endpackage

FILE: rtl/core/lru_page_replacement.sv
// LRU page replacement: timestamped frame table in two memories, one frame scanned per cycle.
`timescale 1ns / 1ps

// One page reference is taken when start is high and busy is low. The block
// scans the searched frames one per cycle through a single read port of the
// page and timestamp memories, looking for a match and for the oldest timestamp
// in the same pass, then writes back the chosen frame. An item holds busy while
// it scans the searched frames (the filled count, at most the effective frame
// count), drains the registered read and writes back; while no frame is filled
// it goes straight to the write-back. Its result word shows on the result
// ports, marked by result_valid for one cycle, in the first cycle with busy low
// again, and a new reference may be started in that same cycle, but not while
// the last one is still in flight. The receiver cannot stall: result_valid marks
// the result word for that one cycle only. frame_count is written through
// cfg_we / cfg_wdata; the user must write it only while the block is idle, which
// the block itself does not enforce. 0 acts as 1 and values above FRAMES act as FRAMES.
module lru_page_replacement #(
	parameter int FRAMES = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     cfg_we,
	input  lru_pr_pkg::fc_t          cfg_wdata,
	// command
	input  logic                     start,
	output logic                     busy,
	input  lru_pr_pkg::page_t        page_number,
	// result
	output logic                     result_valid,
	output logic                     hit,
	output lru_pr_pkg::fidx_t        frame_index,
	output logic                     evicted_valid,
	output lru_pr_pkg::page_t        evicted_page,
	output lru_pr_pkg::ts_t          fault_count
);

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W = $clog2(FRAMES + 1);
	localparam int NW    = (CNT_W > lru_pr_pkg::FC_W) ? CNT_W : lru_pr_pkg::FC_W;
	localparam logic [NW-1:0] FRAMES_N = NW'(FRAMES);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_WRITE = 2'd3;

	logic [1:0]              state_q;
	lru_pr_pkg::fc_t         frame_count_q;
	logic [CNT_W-1:0]        filled_q;
	lru_pr_pkg::ts_t         ref_cnt_q;
	lru_pr_pkg::ts_t         fault_q;

	lru_pr_pkg::page_t       page_q;
	logic [NW-1:0]           n_q;
	logic [NW-1:0]           valid_q;
	logic [NW-1:0]           addr_q;

	lru_pr_pkg::page_t       pages_mem [FRAMES];
	lru_pr_pkg::ts_t         ts_mem    [FRAMES];

	lru_pr_pkg::page_t       rd_page_s1;
	lru_pr_pkg::ts_t         rd_ts_s1;
	logic [IDX_W-1:0]        rd_idx_s1;
	logic                    rd_vld_s1;

	logic                    hit_q;
	logic [IDX_W-1:0]        hit_idx_q;
	lru_pr_pkg::ts_t         min_ts_q;
	logic [IDX_W-1:0]        min_idx_q;
	lru_pr_pkg::page_t       min_page_q;

	logic                    result_valid_q;
	logic                    hit_out_q;
	lru_pr_pkg::fidx_t       frame_index_q;
	logic                    evicted_valid_q;
	lru_pr_pkg::page_t       evicted_page_q;

	logic                    accept;
	logic [NW-1:0]           fc_ext;
	logic [NW-1:0]           eff_n;
	logic [NW-1:0]           filled_ext;
	logic [NW-1:0]           eff_valid;
	logic                    full;
	logic [IDX_W-1:0]        slot;
	logic [NW-1:0]           slot_ext;
	lru_pr_pkg::ts_t         ts_new;
	logic                    do_write;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// Clamp the frame count into 1..FRAMES and limit the search to filled frames
	assign fc_ext     = NW'(frame_count_q);
	assign filled_ext = NW'(filled_q);
	always_comb begin
		if (fc_ext == '0) begin
			eff_n = NW'(1);
		end else if (fc_ext > FRAMES_N) begin
			eff_n = FRAMES_N;
		end else begin
			eff_n = fc_ext;
		end
		eff_valid = (filled_ext < eff_n) ? filled_ext : eff_n;
	end

	// Pick the frame to update once the scan is done
	assign full     = (filled_ext >= n_q);
	assign do_write = (state_q == S_WRITE);
	always_comb begin
		if (hit_q) begin
			slot = hit_idx_q;
		end else if (full) begin
			slot = min_idx_q;
		end else begin
			slot = filled_ext[IDX_W-1:0];
		end
		slot_ext = NW'(slot);
	end
	assign ts_new = (ref_cnt_q == lru_pr_pkg::TS_MAX) ? ref_cnt_q : ref_cnt_q + 1'b1;

	// Frame memories: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (do_write) begin
			ts_mem[slot] <= ts_new;
			if (!hit_q) begin
				pages_mem[slot] <= page_q;
			end
		end
		rd_page_s1 <= pages_mem[addr_q[IDX_W-1:0]];
		rd_ts_s1   <= ts_mem[addr_q[IDX_W-1:0]];
		rd_idx_s1  <= addr_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= lru_pr_pkg::FRAME_COUNT_RST;
		end else if (cfg_we) begin
			frame_count_q <= cfg_wdata;
		end
	end

	// Sequencer: accept, scan, drain the read pipe, write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			addr_q   <= '0;
			filled_q <= '0;
			ref_cnt_q <= '0;
			fault_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					addr_q <= '0;
					if (start) begin
						state_q <= (eff_valid == '0) ? S_WRITE : S_SCAN;
					end
				end
				S_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == valid_q - NW'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					state_q   <= S_IDLE;
					ref_cnt_q <= ts_new;
					if (!hit_q) begin
						if (fault_q != lru_pr_pkg::TS_MAX) begin
							fault_q <= fault_q + 1'b1;
						end
						if (!full) begin
							filled_q <= filled_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Latch the command word
	always_ff @(posedge clk) begin
		if (accept) begin
			page_q  <= page_number;
			n_q     <= eff_n;
			valid_q <= eff_valid;
		end
	end

	// Track first match and oldest frame as read data arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (accept) begin
			hit_q <= 1'b0;
		end else if (rd_vld_s1 && !hit_q && rd_page_s1 == page_q) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (!hit_q && rd_page_s1 == page_q) begin
				hit_idx_q <= rd_idx_s1;
			end
			if (rd_idx_s1 == '0 || rd_ts_s1 < min_ts_q) begin
				min_ts_q   <= rd_ts_s1;
				min_idx_q  <= rd_idx_s1;
				min_page_q <= rd_page_s1;
			end
		end
	end

	// Result valid strobe, high for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= do_write;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			hit_out_q       <= hit_q;
			frame_index_q   <= slot_ext[lru_pr_pkg::FIDX_W-1:0];
			evicted_valid_q <= !hit_q && full;
			evicted_page_q  <= (!hit_q && full) ? min_page_q : '0;
		end
	end

	assign result_valid  = result_valid_q;
	assign hit           = hit_out_q;
	assign frame_index   = frame_index_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;
	assign fault_count   = fault_q;

`ifndef SYNTH
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after a command was taken");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held for more than one cycle");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && hit) |-> !evicted_valid)
		else $error("eviction reported on a hit");

	a_evict_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !evicted_valid) |-> (evicted_page == '0))
		else $error("evicted page not zero without an eviction");

	a_read_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_SCAN || state_q == S_DRAIN))
		else $error("read data returned outside a scan");
`endif

endmodule
